// File: hdl/plmg_pkg.sv
// Package with types, codes and constants shared by the posting list merge blocks.
package plmg_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int CMD_DEPTH       = 2;
    localparam int CMD_PTR_W       = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W       = $clog2(CMD_DEPTH + 1);

    localparam logic [1:0] OP_POST_A = 2'd0;
    localparam logic [1:0] OP_POST_B = 2'd1;
    localparam logic [1:0] OP_END_A  = 2'd2;
    localparam logic [1:0] OP_END_B  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] doc_id;
        logic [31:0] word_id;
        logic [31:0] position;
        logic [31:0] score_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_doc;
        logic [31:0] out_word;
        logic [31:0] out_position;
        logic [31:0] out_score;
        logic        is_posting;
        logic        last;
        logic        overflow;
    } out_item_t;

    typedef struct packed {
        logic [31:0] doc;
        logic [31:0] word;
        logic [31:0] pos;
        logic [31:0] score;
    } posting_t;

    typedef enum logic [1:0] {
        CMD_PUSH_A,
        CMD_PUSH_B,
        CMD_END_A,
        CMD_END_B
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        posting_t  post;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } cmd_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_MERGE,
        ST_SECOND
    } merge_state_t;

endpackage

// File: hdl/plmg_front.sv
// Front end: accepts input transactions, decodes them into commands and queues them.
module plmg_front
    import plmg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    output logic     cmd_valid,
    input  logic     cmd_pop,
    output cmd_t     cmd
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 push;
    logic                 pop;
    cmd_t                 decoded;

    always_comb
    begin
        decoded.post.doc   = item.doc_id;
        decoded.post.word  = item.word_id;
        decoded.post.pos   = item.position;
        decoded.post.score = item.score_value;
        case (item.opcode)
            OP_POST_A: decoded.kind = CMD_PUSH_A;
            OP_POST_B: decoded.kind = CMD_PUSH_B;
            OP_END_A:  decoded.kind = CMD_END_A;
            OP_END_B:  decoded.kind = CMD_END_B;
            default:   decoded.kind = CMD_END_B;
        endcase
    end

    assign item_ready = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = entry_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// File: hdl/plmg_back.sv
// Back end: list FIFOs, head comparison and the registered result stage.
module plmg_back
    import plmg_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    output cmd_ctrl_t cmd_ctrl_pop,
    input  logic      cmd_valid,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    posting_t     mem_a [QUEUE_DEPTH];
    posting_t     mem_b [QUEUE_DEPTH];
    posting_t     head_a_reg;
    posting_t     head_b_reg;
    logic [PTR_W-1:0] wr_a_reg, wr_a_next, rd_a_reg, rd_a_next;
    logic [PTR_W-1:0] wr_b_reg, wr_b_next, rd_b_reg, rd_b_next;
    logic [CNT_W-1:0] count_a_reg, count_a_next, count_b_reg, count_b_next;
    logic         ended_a_reg, ended_a_next, ended_b_reg, ended_b_next;
    logic         overflow_reg, overflow_next;
    logic         emitted_reg, emitted_next;
    merge_state_t state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    out_item_t    out_data_reg, out_data_next;
    logic         push_a, push_b, pop_a, pop_b;
    logic         has_a, has_b, both_end, slot_free, a_less, b_less;
    logic         load;
    posting_t     load_post;
    logic         load_is_post;
    logic         load_last;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        advance = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign has_a     = (count_a_reg != '0);
    assign has_b     = (count_b_reg != '0);
    assign both_end  = ended_a_reg && ended_b_reg;
    assign slot_free = !out_valid_reg || result_ready;
    assign a_less    = (head_a_reg.doc < head_b_reg.doc) ||
                       ((head_a_reg.doc == head_b_reg.doc) && (head_a_reg.pos < head_b_reg.pos));
    assign b_less    = (head_b_reg.doc < head_a_reg.doc) ||
                       ((head_b_reg.doc == head_a_reg.doc) && (head_b_reg.pos < head_a_reg.pos));

    always_comb
    begin
        state_next   = state_reg;
        ended_a_next = ended_a_reg;
        ended_b_next = ended_b_reg;
        overflow_next = overflow_reg;
        emitted_next = emitted_reg;
        push_a       = 1'b0;
        push_b       = 1'b0;
        pop_a        = 1'b0;
        pop_b        = 1'b0;
        load         = 1'b0;
        load_post    = head_a_reg;
        load_is_post = 1'b1;
        load_last    = 1'b0;
        cmd_ctrl_pop.valid = cmd_valid;
        cmd_ctrl_pop.pop   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_ctrl_pop.pop = 1'b1;
                    emitted_next     = 1'b0;
                    state_next       = ST_SETTLE;
                    case (cmd.kind)
                        CMD_PUSH_A:
                        begin
                            if (!ended_a_reg)
                            begin
                                if (count_a_reg == CNT_W'(QUEUE_DEPTH))
                                begin
                                    overflow_next = 1'b1;
                                end
                                else
                                begin
                                    push_a = 1'b1;
                                end
                            end
                        end
                        CMD_PUSH_B:
                        begin
                            if (!ended_b_reg)
                            begin
                                if (count_b_reg == CNT_W'(QUEUE_DEPTH))
                                begin
                                    overflow_next = 1'b1;
                                end
                                else
                                begin
                                    push_b = 1'b1;
                                end
                            end
                        end
                        CMD_END_A: ended_a_next = 1'b1;
                        CMD_END_B: ended_b_next = 1'b1;
                        default:   ended_b_next = 1'b1;
                    endcase
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (has_a && has_b)
                begin
                    if (slot_free)
                    begin
                        load       = 1'b1;
                        state_next = ST_SETTLE;
                        if (a_less)
                        begin
                            pop_a = 1'b1;
                        end
                        else if (b_less)
                        begin
                            pop_b     = 1'b1;
                            load_post = head_b_reg;
                        end
                        else if (head_a_reg.word != head_b_reg.word)
                        begin
                            pop_a      = 1'b1;
                            state_next = ST_SECOND;
                        end
                        else
                        begin
                            pop_a     = 1'b1;
                            pop_b     = 1'b1;
                            load_last = both_end && (count_a_reg == CNT_W'(1)) &&
                                        (count_b_reg == CNT_W'(1));
                        end
                    end
                end
                else if (has_a && ended_b_reg)
                begin
                    if (slot_free)
                    begin
                        load       = 1'b1;
                        pop_a      = 1'b1;
                        load_last  = both_end && (count_a_reg == CNT_W'(1));
                        state_next = ST_SETTLE;
                    end
                end
                else if (has_b && ended_a_reg)
                begin
                    if (slot_free)
                    begin
                        load       = 1'b1;
                        pop_b      = 1'b1;
                        load_post  = head_b_reg;
                        load_last  = both_end && (count_b_reg == CNT_W'(1));
                        state_next = ST_SETTLE;
                    end
                end
                else if (both_end)
                begin
                    if (emitted_reg)
                    begin
                        ended_a_next = 1'b0;
                        ended_b_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else if (slot_free)
                    begin
                        load         = 1'b1;
                        load_post    = '0;
                        load_is_post = 1'b0;
                        load_last    = 1'b1;
                        ended_a_next = 1'b0;
                        ended_b_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SECOND:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    pop_b      = 1'b1;
                    load_post  = head_b_reg;
                    load_last  = both_end && (count_a_reg == '0) &&
                                 (count_b_reg == CNT_W'(1));
                    state_next = ST_SETTLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            emitted_next = 1'b1;
        end
    end

    always_comb
    begin
        wr_a_next    = push_a ? advance(wr_a_reg) : wr_a_reg;
        wr_b_next    = push_b ? advance(wr_b_reg) : wr_b_reg;
        rd_a_next    = pop_a ? advance(rd_a_reg) : rd_a_reg;
        rd_b_next    = pop_b ? advance(rd_b_reg) : rd_b_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (push_a)
        begin
            count_a_next = count_a_reg + 1'b1;
        end
        else if (pop_a)
        begin
            count_a_next = count_a_reg - 1'b1;
        end
        if (push_b)
        begin
            count_b_next = count_b_reg + 1'b1;
        end
        else if (pop_b)
        begin
            count_b_next = count_b_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.out_doc      = load_post.doc;
            out_data_next.out_word     = load_post.word;
            out_data_next.out_position = load_post.pos;
            out_data_next.out_score    = load_post.score;
            out_data_next.is_posting   = load_is_post;
            out_data_next.last         = load_last;
            out_data_next.overflow     = overflow_reg;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_a_reg      <= '0;
            wr_b_reg      <= '0;
            rd_a_reg      <= '0;
            rd_b_reg      <= '0;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            ended_a_reg   <= 1'b0;
            ended_b_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_a_reg      <= wr_a_next;
            wr_b_reg      <= wr_b_next;
            rd_a_reg      <= rd_a_next;
            rd_b_reg      <= rd_b_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            ended_a_reg   <= ended_a_next;
            ended_b_reg   <= ended_b_next;
            overflow_reg  <= overflow_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        head_a_reg   <= mem_a[rd_a_reg];
        head_b_reg   <= mem_b[rd_b_reg];
        if (push_a)
        begin
            mem_a[wr_a_reg] <= cmd.post;
        end
        if (push_b)
        begin
            mem_b[wr_b_reg] <= cmd.post;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// File: hdl/posting_list_two_way_merge_core.sv
// Top level of the two-way posting list merge.
//
// Channel   Direction  Handshake                     Payload
// item      input      item_valid / item_ready       in_item_t   (opcode and posting)
// result    output     result_valid / result_ready   out_item_t  (merged posting and flags)
//
// A command passes through the idle and settle states into the merge state of the engine; each
// result is loaded in the merge or second state; a settle state precedes the next compare, set by
// the registered read of the list memories, whose heads change after every push or pop.
// A two-entry command queue keeps accepting transactions while the engine works.
// Reset is asynchronous and clears all control state; the list memories need no clearing.
// A stalled result holds in the output register and stalls the engine; the queue then fills up.
module posting_list_two_way_merge_core
    import plmg_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    cmd_t      cmd;
    cmd_ctrl_t cmd_ctrl;
    logic      cmd_valid;

    plmg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_ctrl.pop),
        .cmd        (cmd)
    );

    plmg_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_ctrl_pop (cmd_ctrl),
        .cmd_valid    (cmd_valid),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_posting |-> result.last)
        else $error("end marker without last flag");

    a_marker_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_posting |->
            result.out_doc == '0 && result.out_word == '0 &&
            result.out_position == '0 && result.out_score == '0)
        else $error("end marker with nonzero payload");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |=> !result_valid || result.overflow)
        else $error("overflow flag cleared");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ctrl.pop |-> cmd_valid && cmd_ctrl.valid)
        else $error("command popped from empty queue");

endmodule
